>>> rtl/core/scba_pkg.sv
// Shared constants, codes and types of the size-class block allocator.
package scba_pkg;

  localparam int NUM_CLASSES    = 32;
  localparam int GRANULE_BYTES  = 16;
  localparam int CHUNK_GRANULES = 255;
  localparam int POOL_GRANULES  = 65536;

  localparam int SIZE_W     = 16;
  localparam int ADDR_W     = 16;
  localparam int LINK_W     = ADDR_W + 1;
  localparam int LINK_DEPTH = 2 ** ADDR_W;
  localparam int CLASS_W    = $clog2(NUM_CLASSES);
  localparam int GRAN_W     = $clog2(NUM_CLASSES + 1);
  localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
  localparam int LEFT_W     = $clog2(CHUNK_GRANULES + 1);
  localparam int REGION_W   = $clog2(POOL_GRANULES + 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef struct packed {
    logic               action;
    logic               fallback;
    logic [CLASS_W-1:0] cls;
    logic [GRAN_W-1:0]  gran;
    logic [ADDR_W-1:0]  addr;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic              use_fallback;
    logic              status;
  } result_t;

endpackage

>>> rtl/core/scba_req_if.sv
// Request channel of the size-class block allocator.
interface scba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [scba_pkg::SIZE_W-1:0] size_bytes;
  logic [scba_pkg::ADDR_W-1:0] block_addr;

  modport source (output valid, action, size_bytes, block_addr, input ready);
  modport sink (input valid, action, size_bytes, block_addr, output ready);
endinterface

>>> rtl/core/scba_rsp_if.sv
// Response channel of the size-class block allocator.
interface scba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [scba_pkg::ADDR_W-1:0] result_addr;
  logic                        use_fallback;
  logic                        status;

  modport source (output valid, result_addr, use_fallback, status, input ready);
  modport sink (input valid, result_addr, use_fallback, status, output ready);
endinterface

>>> rtl/core/scba_ram.sv
// Generic simple dual-port RAM with registered read.
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/scba_front.sv
// Request intake: granule rounding, class decode and two-entry request queue.
module scba_front (
  input  logic               clk,
  input  logic               rst,
  scba_req_if.sink           req,
  output logic               item_valid,
  output scba_pkg::item_t    item,
  input  logic               item_pop
);

  logic [scba_pkg::SIZE_W:0] size_sum;
  logic [scba_pkg::SIZE_W:0] gran_full;
  scba_pkg::item_t           item_in;
  scba_pkg::item_t           q [2];
  logic                      wr_ptr;
  logic                      rd_ptr;
  logic [1:0]                count;
  logic                      push;

  always_comb begin
    size_sum  = {1'b0, req.size_bytes} + (scba_pkg::SIZE_W + 1)'(scba_pkg::GRANULE_BYTES - 1);
    gran_full = size_sum >> scba_pkg::GRAN_SHIFT;
    item_in.action   = req.action;
    item_in.fallback = (gran_full == '0) ||
                       (gran_full > (scba_pkg::SIZE_W + 1)'(scba_pkg::NUM_CLASSES));
    item_in.gran     = gran_full[scba_pkg::GRAN_W-1:0];
    item_in.cls      = gran_full[scba_pkg::CLASS_W-1:0] - scba_pkg::CLASS_W'(1);
    item_in.addr     = req.block_addr;
  end

  assign req.ready  = (count != 2'd2);
  assign push       = req.valid && req.ready;
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(item_pop);
    end
  end

endmodule

>>> rtl/core/scba_back.sv
// Request execution: class heads, link memory, chunk carving and response register.
module scba_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  scba_pkg::item_t    item,
  output logic               item_pop,
  output logic               res_valid,
  output scba_pkg::result_t  res,
  input  logic               res_ready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_POP  = 4'b0100,
    ST_LEFT = 4'b1000
  } state_t;

  state_t                            state;
  state_t                            state_next;
  scba_pkg::item_t                   cur;
  logic [scba_pkg::ADDR_W-1:0]       ret_addr;
  logic [scba_pkg::ADDR_W-1:0]       ret_addr_next;
  logic [scba_pkg::NUM_CLASSES-1:0]  nonempty;
  logic [scba_pkg::NUM_CLASSES-1:0]  nonempty_next;
  logic [scba_pkg::ADDR_W-1:0]       carve_ptr;
  logic [scba_pkg::ADDR_W-1:0]       carve_ptr_next;
  logic [scba_pkg::LEFT_W-1:0]       carve_left;
  logic [scba_pkg::LEFT_W-1:0]       carve_left_next;
  logic [scba_pkg::REGION_W-1:0]     region_next;
  logic [scba_pkg::REGION_W-1:0]     region_next_next;
  scba_pkg::result_t                 res_next;
  logic                              done;

  logic                              h_we;
  logic [scba_pkg::CLASS_W-1:0]      h_waddr;
  logic [scba_pkg::ADDR_W-1:0]       h_wdata;
  logic [scba_pkg::CLASS_W-1:0]      h_raddr;
  logic [scba_pkg::ADDR_W-1:0]       h_rdata;
  logic                              l_we;
  logic [scba_pkg::ADDR_W-1:0]       l_waddr;
  logic [scba_pkg::LINK_W-1:0]       l_wdata;
  logic [scba_pkg::ADDR_W-1:0]       l_raddr;
  logic [scba_pkg::LINK_W-1:0]       l_rdata;

  logic [scba_pkg::CLASS_W-1:0]      left_cls;
  logic                              fits;
  logic                              exhausted;
  logic [scba_pkg::ADDR_W-1:0]       chunk_ptr;
  logic [scba_pkg::LEFT_W-1:0]       chunk_left;
  logic [scba_pkg::REGION_W-1:0]     chunk_region;

  scba_ram #(
    .WIDTH (scba_pkg::ADDR_W),
    .DEPTH (scba_pkg::NUM_CLASSES)
  ) u_head_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  scba_ram #(
    .WIDTH (scba_pkg::LINK_W),
    .DEPTH (scba_pkg::LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign item_pop = (state == ST_IDLE) && item_valid && (!res_valid || res_ready);

  always_comb begin
    left_cls     = carve_left[scba_pkg::CLASS_W-1:0] - scba_pkg::CLASS_W'(1);
    fits         = carve_left >= scba_pkg::LEFT_W'(cur.gran);
    exhausted    = ({1'b0, region_next} + (scba_pkg::REGION_W + 1)'(scba_pkg::CHUNK_GRANULES)) >
                   (scba_pkg::REGION_W + 1)'(scba_pkg::POOL_GRANULES);
    chunk_ptr    = region_next[scba_pkg::ADDR_W-1:0] + scba_pkg::ADDR_W'(cur.gran);
    chunk_left   = scba_pkg::LEFT_W'(scba_pkg::CHUNK_GRANULES) - scba_pkg::LEFT_W'(cur.gran);
    chunk_region = region_next + scba_pkg::REGION_W'(scba_pkg::CHUNK_GRANULES);
  end

  always_comb begin
    state_next       = state;
    ret_addr_next    = ret_addr;
    nonempty_next    = nonempty;
    carve_ptr_next   = carve_ptr;
    carve_left_next  = carve_left;
    region_next_next = region_next;
    done             = 1'b0;
    res_next         = res;
    h_we             = 1'b0;
    h_waddr          = cur.cls;
    h_wdata          = cur.addr;
    h_raddr          = left_cls;
    l_we             = 1'b0;
    l_waddr          = cur.addr;
    l_wdata          = {nonempty[cur.cls], h_rdata};
    l_raddr          = h_rdata;

    unique case (state)
      ST_IDLE: begin
        h_raddr = item.cls;
        if (item_pop) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_next.result_addr  = '0;
        res_next.use_fallback = 1'b0;
        res_next.status       = scba_pkg::STATUS_OK;
        if (cur.fallback) begin
          res_next.use_fallback = 1'b1;
          done = 1'b1;
        end else if (cur.action == scba_pkg::ACT_FREE) begin
          l_we = 1'b1;
          h_we = 1'b1;
          nonempty_next[cur.cls] = 1'b1;
          done = 1'b1;
        end else if (nonempty[cur.cls]) begin
          ret_addr_next = h_rdata;
          state_next    = ST_POP;
        end else if (fits) begin
          res_next.result_addr = carve_ptr;
          carve_ptr_next       = carve_ptr + scba_pkg::ADDR_W'(cur.gran);
          carve_left_next      = carve_left - scba_pkg::LEFT_W'(cur.gran);
          done = 1'b1;
        end else if (exhausted) begin
          res_next.status = scba_pkg::STATUS_EXHAUSTED;
          done = 1'b1;
        end else if (carve_left != '0) begin
          state_next = ST_LEFT;
        end else begin
          res_next.result_addr = region_next[scba_pkg::ADDR_W-1:0];
          carve_ptr_next       = chunk_ptr;
          carve_left_next      = chunk_left;
          region_next_next     = chunk_region;
          done = 1'b1;
        end
      end
      ST_POP: begin
        h_we    = 1'b1;
        h_wdata = l_rdata[scba_pkg::ADDR_W-1:0];
        nonempty_next[cur.cls] = l_rdata[scba_pkg::ADDR_W];
        res_next.result_addr   = ret_addr;
        res_next.use_fallback  = 1'b0;
        res_next.status        = scba_pkg::STATUS_OK;
        done = 1'b1;
      end
      ST_LEFT: begin
        l_we    = 1'b1;
        l_waddr = carve_ptr;
        l_wdata = {nonempty[left_cls], h_rdata};
        h_we    = 1'b1;
        h_waddr = left_cls;
        h_wdata = carve_ptr;
        nonempty_next[left_cls] = 1'b1;
        res_next.result_addr  = region_next[scba_pkg::ADDR_W-1:0];
        res_next.use_fallback = 1'b0;
        res_next.status       = scba_pkg::STATUS_OK;
        carve_ptr_next   = chunk_ptr;
        carve_left_next  = chunk_left;
        region_next_next = chunk_region;
        done = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (done) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur <= item;
    end
    ret_addr <= ret_addr_next;
    if (done) begin
      res <= res_next;
    end
    if (rst) begin
      state       <= ST_IDLE;
      nonempty    <= '0;
      carve_ptr   <= '0;
      carve_left  <= '0;
      region_next <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      nonempty    <= nonempty_next;
      carve_ptr   <= carve_ptr_next;
      carve_left  <= carve_left_next;
      region_next <= region_next_next;
      res_valid   <= done || (res_valid && !res_ready);
    end
  end

endmodule

>>> rtl/core/size_class_block_allocator.sv
// Top level of the size-class block allocator.
// Allocates and frees blocks of 1 to 32 granules (16 bytes each) from a 65536-granule
// pool, one response per request, in request order. Free and fallback requests, and
// allocations served from the current chunk or from a fresh chunk when nothing is left
// over, end in the execute state; class-list pops and leftover-pushing refills add a
// pop or leftover state, set by the registered link-memory read and the single read
// port of the class-head memory. A two-entry queue holds requests while one executes.
// Pool exhaustion answers status 1 with address 0 and leaves all state as it was.
module size_class_block_allocator (
  input logic          clk,
  input logic          rst,
  scba_req_if.sink     req,
  scba_rsp_if.source   rsp
);

  logic              item_valid;
  scba_pkg::item_t   item;
  logic              item_pop;
  logic              res_valid;
  scba_pkg::result_t res;

  scba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  scba_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (rsp.ready)
  );

  assign rsp.valid        = res_valid;
  assign rsp.result_addr  = res.result_addr;
  assign rsp.use_fallback = res.use_fallback;
  assign rsp.status       = res.status;

  a_fallback_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.use_fallback |-> rsp.result_addr == '0 &&
                                      rsp.status == scba_pkg::STATUS_OK)
    else $error("fallback response carries an address or status");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == scba_pkg::STATUS_EXHAUSTED |-> rsp.result_addr == '0)
    else $error("exhausted response carries an address");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid && (!rsp.valid || rsp.ready))
    else $error("request taken from queue while response slot is held");

  a_pop_spacing: assert property (@(posedge clk) disable iff (rst)
    item_pop |=> !item_pop)
    else $error("requests taken from queue in consecutive cycles");

endmodule
